>>> sv/tsr_pkg.sv
package tsr_pkg;

  localparam int unsigned PidEntries  = 16;
  localparam int unsigned EntryW      = $clog2(PidEntries);
  localparam int unsigned PacketBytes = 188;
  localparam int unsigned SectionMax  = 4096;
  localparam int unsigned FifoDepth   = 4;
  localparam int unsigned FifoPtrW    = $clog2(FifoDepth);

  localparam logic [7:0]  PacketLast  = 8'(PacketBytes - 1);
  localparam logic [8:0]  PacketLen9  = 9'(PacketBytes);
  localparam logic [12:0] SectionMax13 = 13'(SectionMax);

  // output kinds
  localparam logic [1:0] KindByte    = 2'd0;
  localparam logic [1:0] KindByteEnd = 2'd1;
  localparam logic [1:0] KindEnd     = 2'd2;

  typedef enum logic [2:0] {
    OpAlloc,
    OpFlush,
    OpPointer,
    OpBody,
    OpTail
  } op_e;

  typedef struct packed {
    op_e                op;
    logic [EntryW-1:0]  entry;
    logic [12:0]        pid;
    logic [7:0]         data;
    logic               last;     // body: section ends at this byte
    logic               full_ptr; // pointer: pointer runs to the packet end
    logic               zero_ptr; // pointer: pointer field is zero
  } word_t;

endpackage

>>> sv/tsr_fifo.sv
module tsr_fifo
  import tsr_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  wr_i,
  input  word_t wdata_i,
  output logic  full_o,
  input  logic  rd_i,
  output logic  empty_o,
  output word_t rdata_o
);

  word_t               mem_q [FifoDepth];
  logic [FifoPtrW-1:0] wptr_q, rptr_q;
  logic [FifoPtrW:0]   cnt_q;

  assign full_o  = (cnt_q == (FifoPtrW+1)'(FifoDepth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (wr_i) wptr_q <= wptr_q + 1'b1;
      if (rd_i) rptr_q <= rptr_q + 1'b1;
      cnt_q <= cnt_q + (FifoPtrW+1)'(wr_i) - (FifoPtrW+1)'(rd_i);
    end
  end

endmodule

>>> sv/tsr_front.sv
module tsr_front
  import tsr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic       action_i,
  input  logic [7:0] data_byte_i,
  input  logic       packet_start_i,
  output logic       wr_o,
  output word_t      word_o
);

  logic [7:0]        pos_q, pos_d;
  logic [12:0]       pid_q, pid_d;
  logic [EntryW-1:0] cur_q, cur_d;
  logic [1:0]        am_q, am_d;
  logic              us_q, us_d;
  logic [7:0]        pb_q, pb_d;
  logic [8:0]        pe_q, pe_d;
  logic              drop_q, drop_d;
  logic [PidEntries-1:0] valid_q, valid_d;
  logic [12:0]       epid_q [PidEntries];

  logic [7:0]        idx;
  logic              live;
  logic [12:0]       full_pid;
  logic              hit, free;
  logic [EntryW-1:0] hit_idx, free_idx;
  logic [8:0]        rb, idx1, ad_end;
  logic              alloc;

  assign full_pid = {pid_q[12:8], data_byte_i};
  assign idx1     = {1'b0, idx} + 9'd1;
  assign rb       = idx1 + {1'b0, data_byte_i};
  assign ad_end   = {1'b0, data_byte_i} + 9'd5;

  always_comb begin
    hit      = 1'b0;
    hit_idx  = '0;
    free     = 1'b0;
    free_idx = '0;
    for (int i = PidEntries - 1; i >= 0; i--) begin
      if (valid_q[i] && epid_q[i] == full_pid) begin
        hit     = 1'b1;
        hit_idx = EntryW'(i);
      end
      if (!valid_q[i]) begin
        free     = 1'b1;
        free_idx = EntryW'(i);
      end
    end
  end

  always_comb begin
    pos_d   = pos_q;
    pid_d   = pid_q;
    cur_d   = cur_q;
    am_d    = am_q;
    us_d    = us_q;
    pb_d    = pb_q;
    pe_d    = pe_q;
    drop_d  = drop_q;
    valid_d = valid_q;
    alloc   = 1'b0;
    wr_o    = 1'b0;
    word_o  = '{op: OpBody, entry: cur_q, pid: pid_q, data: data_byte_i,
                last: 1'b0, full_ptr: 1'b0, zero_ptr: 1'b0};
    idx     = packet_start_i ? 8'd0 : pos_q;
    live    = packet_start_i || (pos_q != 8'd0);

    if (accept_i) begin
      if (action_i) begin
        valid_d   = '0;
        pos_d     = 8'd0;
        wr_o      = 1'b1;
        word_o.op = OpFlush;
      end else if (live) begin
        pos_d = (idx == PacketLast) ? 8'd0 : idx + 8'd1;
        if (idx == 8'd0) begin
          drop_d = 1'b0;
          us_d   = 1'b0;
          pid_d  = '0;
          am_d   = '0;
          pb_d   = 8'(PacketBytes);
          pe_d   = PacketLen9;
        end else if (!drop_q) begin
          if (idx == 8'd1) begin
            us_d  = data_byte_i[6];
            pid_d = {data_byte_i[4:0], 8'd0};
          end else if (idx == 8'd2) begin
            pid_d = full_pid;
            if (hit) begin
              cur_d = hit_idx;
            end else if (free) begin
              cur_d              = free_idx;
              valid_d[free_idx]  = 1'b1;
              alloc              = 1'b1;
              wr_o               = 1'b1;
              word_o.op          = OpAlloc;
              word_o.entry       = free_idx;
            end else begin
              drop_d = 1'b1;
            end
          end else if (idx == 8'd3) begin
            am_d = data_byte_i[5:4];
            if (data_byte_i[4] == 1'b0) drop_d = 1'b1;
            else pb_d = data_byte_i[5] ? 8'd5 : 8'd4;
            pe_d = PacketLen9;
          end else if (idx == 8'd4 && am_q == 2'd3) begin
            if (ad_end > PacketLen9) drop_d = 1'b1;
            else pb_d = ad_end[7:0];
          end else if (idx >= pb_q) begin
            if (us_q && idx == pb_q) begin
              if (rb > PacketLen9) begin
                drop_d = 1'b1;
              end else begin
                pe_d            = rb;
                wr_o            = 1'b1;
                word_o.op       = OpPointer;
                word_o.full_ptr = (rb == PacketLen9);
                word_o.zero_ptr = (data_byte_i == 8'd0);
              end
            end else if ({1'b0, idx} < pe_q) begin
              wr_o        = 1'b1;
              word_o.op   = OpBody;
              word_o.last = us_q && (idx1 == pe_q);
            end else begin
              wr_o      = 1'b1;
              word_o.op = OpTail;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (alloc) epid_q[free_idx] <= full_pid;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      pid_q   <= '0;
      cur_q   <= '0;
      am_q    <= '0;
      us_q    <= 1'b0;
      pb_q    <= '0;
      pe_q    <= '0;
      drop_q  <= 1'b0;
      valid_q <= '0;
    end else begin
      pos_q   <= pos_d;
      pid_q   <= pid_d;
      cur_q   <= cur_d;
      am_q    <= am_d;
      us_q    <= us_d;
      pb_q    <= pb_d;
      pe_q    <= pe_d;
      drop_q  <= drop_d;
      valid_q <= valid_d;
    end
  end

endmodule

>>> sv/tsr_back.sv
module tsr_back
  import tsr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [12:0] section_limit_i,
  input  logic        fifo_empty_i,
  input  word_t       word_i,
  output logic        fifo_rd_o,
  output logic        empty_o,
  input  logic        pop_i,
  output logic [12:0] stream_pid_o,
  output logic [7:0]  section_byte_o,
  output logic [11:0] byte_offset_o,
  output logic [1:0]  kind_o,
  output logic [12:0] section_length_o
);

  logic [PidEntries-1:0] col_q, col_d;
  logic [12:0]           fill_q [PidEntries];
  logic                  fill_we;
  logic [12:0]           fill_wd;

  logic        ov_q, ov_d;
  logic [12:0] opid_q, olen_q, olen_d;
  logic [7:0]  obyte_q, obyte_d;
  logic [11:0] ooff_q, ooff_d;
  logic [1:0]  okind_q, okind_d;
  logic        emit;

  logic [12:0] lim, fill, f;
  logic        col;

  assign lim       = (section_limit_i > SectionMax13) ? SectionMax13 : section_limit_i;
  assign fifo_rd_o = !fifo_empty_i && (!ov_q || pop_i);
  assign fill      = fill_q[word_i.entry];
  assign col       = col_q[word_i.entry];
  assign f         = col ? fill : 13'd0;

  always_comb begin
    col_d   = col_q;
    fill_we = 1'b0;
    fill_wd = '0;
    emit    = 1'b0;
    obyte_d = word_i.data;
    ooff_d  = fill[11:0];
    okind_d = KindByte;
    olen_d  = '0;
    if (fifo_rd_o) begin
      case (word_i.op)
        OpFlush: col_d = '0;
        OpAlloc: col_d[word_i.entry] = 1'b0;
        OpPointer: begin
          if (!col) begin
            if (word_i.full_ptr) begin
              col_d[word_i.entry] = 1'b1;
              fill_we = 1'b1;
            end
          end else if (word_i.zero_ptr) begin
            fill_we = 1'b1;
            emit    = 1'b1;
            obyte_d = '0;
            ooff_d  = '0;
            okind_d = KindEnd;
            olen_d  = fill;
          end
        end
        OpBody: begin
          if (col) begin
            if (fill < lim) begin
              fill_we = 1'b1;
              emit    = 1'b1;
              if (word_i.last) begin
                okind_d = KindByteEnd;
                olen_d  = fill + 13'd1;
              end else begin
                fill_wd = fill + 13'd1;
              end
            end else if (word_i.last) begin
              fill_we = 1'b1;
              emit    = 1'b1;
              obyte_d = '0;
              ooff_d  = '0;
              okind_d = KindEnd;
              olen_d  = fill;
            end
          end
        end
        OpTail: begin
          col_d[word_i.entry] = 1'b1;
          fill_we = 1'b1;
          fill_wd = f;
          ooff_d  = f[11:0];
          if (f < lim) begin
            fill_wd = f + 13'd1;
            emit    = 1'b1;
          end
        end
        default: ;
      endcase
    end
    ov_d = emit ? 1'b1 : (pop_i ? 1'b0 : ov_q);
  end

  always_ff @(posedge clk_i) begin
    if (fill_we) fill_q[word_i.entry] <= fill_wd;
    if (emit) begin
      opid_q  <= word_i.pid;
      obyte_q <= obyte_d;
      ooff_q  <= ooff_d;
      okind_q <= okind_d;
      olen_q  <= olen_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      ov_q  <= 1'b0;
    end else begin
      col_q <= col_d;
      ov_q  <= ov_d;
    end
  end

  assign empty_o          = !ov_q;
  assign stream_pid_o     = opid_q;
  assign section_byte_o   = obyte_q;
  assign byte_offset_o    = ooff_q;
  assign kind_o           = okind_q;
  assign section_length_o = olen_q;

endmodule

>>> sv/ts_section_reassembler.sv
// Transport stream section reassembler. Packet bytes go in one per cycle
// while full is low (packet_start on byte 0, action=1 flushes the PID
// table); section bytes come out with their PID and offset, plus section-end
// words. The front parses the header and looks up the PID in the cycle a
// byte is accepted, and writes a word into a four-word queue at that same
// edge. The section unit takes one word per cycle while its result register
// is empty or popped, updates the per-PID fill count and loads the result
// register. Sustained rate is one byte per cycle while results are popped as
// they appear. A result that is not popped holds the section unit, and full
// rises once the queue has filled behind it. section_limit sits at byte
// address 0 and may be written only while the block is idle.
module ts_section_reassembler
  import tsr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        push,
  output logic        full,
  input  logic        action_i,
  input  logic [7:0]  data_byte_i,
  input  logic        packet_start_i,
  output logic        empty,
  input  logic        pop,
  output logic [12:0] stream_pid_o,
  output logic [7:0]  section_byte_o,
  output logic [11:0] byte_offset_o,
  output logic [1:0]  kind_o,
  output logic [12:0] section_length_o
);

  logic [12:0] limit_q;
  logic        fifo_full, fifo_empty, fifo_wr, fifo_rd, front_wr;
  word_t       wword, rword;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {19'd0, limit_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= SectionMax13;
    end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
      limit_q <= pwdata[12:0];
    end
  end

  assign full    = fifo_full;
  assign fifo_wr = front_wr;

  tsr_front u_front (
    .clk_i,
    .rst_ni,
    .accept_i      (push && !fifo_full),
    .action_i,
    .data_byte_i,
    .packet_start_i,
    .wr_o          (front_wr),
    .word_o        (wword)
  );

  tsr_fifo u_fifo (
    .clk_i,
    .rst_ni,
    .wr_i    (fifo_wr),
    .wdata_i (wword),
    .full_o  (fifo_full),
    .rd_i    (fifo_rd),
    .empty_o (fifo_empty),
    .rdata_o (rword)
  );

  tsr_back u_back (
    .clk_i,
    .rst_ni,
    .section_limit_i  (limit_q),
    .fifo_empty_i     (fifo_empty),
    .word_i           (rword),
    .fifo_rd_o        (fifo_rd),
    .empty_o          (empty),
    .pop_i            (pop),
    .stream_pid_o,
    .section_byte_o,
    .byte_offset_o,
    .kind_o,
    .section_length_o
  );

endmodule

>>> tb/tb_ts_section_reassembler.sv
module tb_ts_section_reassembler;
  import tsr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 2000000;
  localparam int unsigned DrainCycles = 12;

  typedef struct {
    logic [12:0] pid;
    logic [7:0]  sbyte;
    logic [11:0] offset;
    logic [1:0]  kind;
    logic [12:0] length;
  } section_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        push = 1'b0;
  logic        full;
  logic        action_i = 1'b0;
  logic [7:0]  data_byte_i = '0;
  logic        packet_start_i = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [12:0] stream_pid_o;
  logic [7:0]  section_byte_o;
  logic [11:0] byte_offset_o;
  logic [1:0]  kind_o;
  logic [12:0] section_length_o;

  ts_section_reassembler u_top (.*);

  always #5ns clk_i = ~clk_i;

  int unsigned cycles = 0;
  int unsigned fails = 0;
  int unsigned n_bytes = 0;
  int unsigned n_packets = 0;
  int unsigned n_words = 0;
  int unsigned n_ends = 0;
  bit          push_burst = 1'b0;
  bit          pop_burst = 1'b0;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("[ts_section_reassembler] ERROR");
      $finish;
    end
  end

  // section predictor state
  logic [12:0]   sec_limit;
  logic [12:0]   tbl_pid[PidEntries];
  bit            tbl_valid[PidEntries];
  bit            tbl_collect[PidEntries];
  int unsigned   tbl_fill[PidEntries];
  int unsigned   pkt_pos;
  logic [12:0]   pkt_pid;
  int unsigned   pkt_entry;
  int unsigned   pkt_afc;
  bit            pkt_unit_start;
  int unsigned   pkt_payload;
  int unsigned   pkt_ptr_end;
  bit            pkt_drop;
  section_word_t section_q[$];

  function automatic void clear_pid_table();
    for (int i = 0; i < PidEntries; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_collect[i] = 1'b0;
      tbl_fill[i] = 0;
      tbl_pid[i] = '0;
    end
  endfunction

  function automatic void add_word(logic [1:0] kind, logic [7:0] b, int unsigned off,
                                   int unsigned len);
    section_word_t w;
    w.pid = pkt_pid;
    w.sbyte = b;
    w.offset = off[11:0];
    w.kind = kind;
    w.length = len[12:0];
    section_q.push_back(w);
  endfunction

  function automatic void lookup_pid();
    for (int i = 0; i < PidEntries; i++) begin
      if (tbl_valid[i] && tbl_pid[i] == pkt_pid) begin
        pkt_entry = i;
        return;
      end
    end
    for (int i = 0; i < PidEntries; i++) begin
      if (!tbl_valid[i]) begin
        tbl_valid[i] = 1'b1;
        tbl_pid[i] = pkt_pid;
        tbl_collect[i] = 1'b0;
        tbl_fill[i] = 0;
        pkt_entry = i;
        return;
      end
    end
    pkt_drop = 1'b1;
  endfunction

  function automatic void predict_section(bit act, logic [7:0] b, bit ps);
    int unsigned idx, e, fill, lim, rb;
    bit last;
    if (act) begin
      clear_pid_table();
      pkt_pos = 0;
      return;
    end
    if (ps) idx = 0;
    else if (pkt_pos == 0) return;
    else idx = pkt_pos;
    pkt_pos = (idx + 1 >= PacketBytes) ? 0 : idx + 1;
    if (idx == 0) begin
      pkt_drop = 1'b0;
      pkt_unit_start = 1'b0;
      pkt_pid = '0;
      pkt_afc = 0;
      pkt_payload = PacketBytes;
      pkt_ptr_end = PacketBytes;
      return;
    end
    if (pkt_drop) return;
    if (idx == 1) begin
      pkt_unit_start = b[6];
      pkt_pid = {b[4:0], 8'h00};
      return;
    end
    if (idx == 2) begin
      pkt_pid[7:0] = b;
      lookup_pid();
      return;
    end
    if (idx == 3) begin
      pkt_afc = b[5:4];
      if (pkt_afc == 0 || pkt_afc == 2) pkt_drop = 1'b1;
      else pkt_payload = (pkt_afc == 3) ? 5 : 4;
      pkt_ptr_end = PacketBytes;
      return;
    end
    if (idx == 4 && pkt_afc == 3) begin
      if (b + 5 > PacketBytes) pkt_drop = 1'b1;
      else pkt_payload = b + 5;
      return;
    end
    if (idx < pkt_payload) return;
    e = pkt_entry % PidEntries;
    lim = (sec_limit > SectionMax) ? SectionMax : sec_limit;
    if (pkt_unit_start && idx == pkt_payload) begin
      rb = idx + 1 + b;
      if (rb > PacketBytes) begin
        pkt_drop = 1'b1;
        return;
      end
      pkt_ptr_end = rb;
      if (!tbl_collect[e]) begin
        if (rb == PacketBytes) begin
          tbl_collect[e] = 1'b1;
          tbl_fill[e] = 0;
        end
        return;
      end
      if (rb == idx + 1) begin
        fill = tbl_fill[e];
        tbl_fill[e] = 0;
        add_word(KindEnd, 8'h00, 0, fill);
      end
      return;
    end
    if (idx < pkt_ptr_end) begin
      if (!tbl_collect[e]) return;
      last = pkt_unit_start && (idx + 1 == pkt_ptr_end);
      fill = tbl_fill[e];
      if (fill < lim) begin
        tbl_fill[e] = fill + 1;
        if (last) begin
          tbl_fill[e] = 0;
          add_word(KindByteEnd, b, fill, fill + 1);
        end else begin
          add_word(KindByte, b, fill, 0);
        end
      end else if (last) begin
        tbl_fill[e] = 0;
        add_word(KindEnd, 8'h00, 0, fill);
      end
      return;
    end
    if (!tbl_collect[e]) begin
      tbl_collect[e] = 1'b1;
      tbl_fill[e] = 0;
    end
    fill = tbl_fill[e];
    if (fill < lim) begin
      tbl_fill[e] = fill + 1;
      add_word(KindByte, b, fill, 0);
    end
  endfunction

  // result side: random pop stalls, compare against the oldest prediction
  initial begin
    int unsigned stall;
    section_word_t w;
    stall = 0;
    forever begin
      @(negedge clk_i);
      if (stall > 0) begin
        pop = 1'b0;
        stall--;
      end else begin
        pop = 1'b1;
      end
      @(posedge clk_i);
      if (rst_ni && pop && !empty) begin
        n_words++;
        if (section_q.size() == 0) begin
          $error("unexpected word: pid %0d kind %0d", stream_pid_o, kind_o);
          fails++;
        end else begin
          w = section_q.pop_front();
          if (kind_o != KindByte) n_ends++;
          if (stream_pid_o !== w.pid) begin
            $error("stream_pid exp %0d got %0d", w.pid, stream_pid_o); fails++;
          end
          if (section_byte_o !== w.sbyte) begin
            $error("section_byte exp %0h got %0h", w.sbyte, section_byte_o); fails++;
          end
          if (byte_offset_o !== w.offset) begin
            $error("byte_offset exp %0d got %0d", w.offset, byte_offset_o); fails++;
          end
          if (kind_o !== w.kind) begin
            $error("kind exp %0d got %0d", w.kind, kind_o); fails++;
          end
          if (section_length_o !== w.length) begin
            $error("section_length exp %0d got %0d", w.length, section_length_o); fails++;
          end
        end
        stall = pop_burst ? 0 : (($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 17));
      end
    end
  end

  task automatic send_word(bit act, logic [7:0] b, bit ps);
    int unsigned gap;
    gap = push_burst ? 0 : (($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 17));
    if (gap > 0) begin
      push = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    push = 1'b1;
    action_i = act;
    data_byte_i = b;
    packet_start_i = ps;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    predict_section(act, b, ps);
    n_bytes++;
    @(negedge clk_i);
  endtask

  task automatic idle_inputs();
    push = 1'b0;
    action_i = 1'b0;
    packet_start_i = 1'b0;
  endtask

  // send the first nbytes of one packet; bytes past the header are random
  task automatic send_packet(logic [12:0] pid, bit us, logic [1:0] afc, logic [7:0] alen,
                             logic [7:0] ptr, int unsigned nbytes);
    logic [7:0] pk[PacketBytes];
    int unsigned pay;
    for (int i = 0; i < PacketBytes; i++) pk[i] = 8'($urandom);
    pk[0] = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h47;
    pk[1] = {pk[1][7], us, pk[1][5], pid[12:8]};
    pk[2] = pid[7:0];
    pk[3] = {pk[3][7:6], afc, pk[3][3:0]};
    pay = 4;
    if (afc == 2'd3) begin
      pk[4] = alen;
      pay = 5 + alen;
    end
    if (us && pay < PacketBytes) pk[pay] = ptr;
    n_packets++;
    for (int i = 0; i < nbytes; i++) send_word(1'b0, pk[i], i == 0);
    idle_inputs();
  endtask

  task automatic send_flush();
    send_word(1'b1, 8'($urandom), 1'($urandom));
    idle_inputs();
  endtask

  task automatic drain();
    wait (section_q.size() == 0);
    repeat (DrainCycles) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic set_section_limit(logic [12:0] lim);
    psel = 1'b1; penable = 1'b0; pwrite = 1'b1; paddr = '0; pwdata = 32'(lim);
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    sec_limit = lim;
    @(negedge clk_i);
    pwrite = 1'b0; penable = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata[12:0] !== lim) begin
      $error("section_limit readback exp %0d got %0d", lim, prdata[12:0]);
      fails++;
    end
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0;
  endtask

  // header corner cases, pointer cases, stray and short packets
  task automatic test_directed();
    send_word(1'b0, 8'hAA, 1'b0);                      // stray byte, no packet open
    send_packet(13'd0, 1'b1, 2'd1, 8'd0, 8'd183, 12);  // pointer to packet end
    send_packet(13'd0, 1'b0, 2'd1, 8'd0, 8'd0, 40);    // continuation
    send_packet(13'd0, 1'b1, 2'd1, 8'd0, 8'd0, 12);    // zero pointer ends section
    send_packet(13'd0, 1'b1, 2'd3, 8'd10, 8'd20, 50);  // end mid packet
    send_packet(13'h1FFF, 1'b1, 2'd3, 8'd183, 8'd0, 12); // no room for pointer
    send_packet(13'h1FFF, 1'b1, 2'd3, 8'd184, 8'd0, 8);  // adaptation too long
    send_packet(13'h1FFF, 1'b0, 2'd3, 8'd182, 8'd0, 8);
    send_packet(13'd5, 1'b1, 2'd1, 8'd0, 8'd184, 10);  // pointer past packet
    send_packet(13'd6, 1'b0, 2'd0, 8'd0, 8'd0, 6);     // reserved control
    send_packet(13'd6, 1'b0, 2'd2, 8'd0, 8'd0, 6);     // adaptation only
    send_packet(13'd0, 1'b0, 2'd1, 8'd0, 8'd0, 40);    // short packet
    send_packet(13'd0, 1'b1, 2'd1, 8'd0, 8'd10, 40);
    send_flush();
    drain();
  endtask

  task automatic test_table_full();
    for (int i = 0; i < PidEntries + 2; i++)
      send_packet(13'(100 + i), 1'b1, 2'd1, 8'd0, 8'd183, 4);
    send_packet(13'(100 + PidEntries + 1), 1'b1, 2'd1, 8'd0, 8'd183, 10);
    send_packet(13'd100, 1'b1, 2'd1, 8'd0, 8'd183, 10);
    send_packet(13'd100, 1'b1, 2'd1, 8'd0, 8'd50, 60);
    send_flush();
    drain();
  endtask

  task automatic test_random(int unsigned n_target);
    logic [12:0] pids[6];
    int unsigned stop_at, r, nb;
    logic [1:0] afc;
    logic [7:0] alen, ptr;
    pids = '{13'd0, 13'h1FFF, 13'd17, 13'h0AAA, 13'h1555, 13'($urandom)};
    stop_at = n_bytes + n_target;
    while (n_bytes < stop_at) begin
      r = $urandom_range(0, 99);
      push_burst = ($urandom_range(0, 3) == 0);
      pop_burst = ($urandom_range(0, 3) == 0);
      if (r < 3) begin
        send_flush();
      end else if (r < 6) begin
        send_word(1'b0, 8'($urandom), 1'b0);
        idle_inputs();
      end else begin
        afc = ($urandom_range(0, 9) == 0) ? 2'($urandom) :
              (($urandom_range(0, 2) == 0) ? 2'd3 : 2'd1);
        alen = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 20));
        ptr = ($urandom_range(0, 9) == 0) ? 8'($urandom) :
              (($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(0, 60)));
        nb = ($urandom_range(0, 7) == 0) ? PacketBytes : $urandom_range(1, 60);
        send_packet(pids[$urandom_range(0, 5)], 1'($urandom), afc, alen, ptr, nb);
      end
    end
    push_burst = 1'b0;
    pop_burst = 1'b0;
    drain();
  endtask

  initial begin
    sec_limit = 13'd4096;
    clear_pid_table();
    pkt_pos = 0; pkt_pid = '0; pkt_entry = 0; pkt_afc = 0; pkt_unit_start = 1'b0;
    pkt_payload = 0; pkt_ptr_end = 0; pkt_drop = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed();
    test_table_full();
    set_section_limit(13'd1);
    test_random(70);
    set_section_limit(13'd5);
    send_packet(13'd9, 1'b1, 2'd1, 8'd0, 8'd183, 10);
    send_packet(13'd9, 1'b1, 2'd1, 8'd0, 8'd30, 40);
    drain();
    set_section_limit(13'd8191);
    test_random(100);
    set_section_limit(13'd100);
    test_random(100);
    set_section_limit(13'd4096);
    test_random(120);

    $display("covered %0d pushed bytes in %0d packets, %0d words out (%0d section ends)",
             n_bytes, n_packets, n_words, n_ends);
    $display("section limits 1, 5, 100, 4096 and 8191; flushes, full PID table, short packets");
    if (fails == 0) begin
      $display("[ts_section_reassembler] OK");
    end else begin
      $display("[ts_section_reassembler] ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/tsr_pkg.sv
sv/tsr_fifo.sv
sv/tsr_front.sv
sv/tsr_back.sv
sv/ts_section_reassembler.sv
tb/tb_ts_section_reassembler.sv
